@@ hdl/mic_pkg.sv @@
// Package with the shared constants, types and helper functions of the intersection counter.
package mic_pkg;

  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned COUNT_BITS    = 16;
  localparam int unsigned ADDR_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned LOW_W         = 60;
  localparam int unsigned HIGH_W        = 15;
  localparam int unsigned WORD_W        = LOW_W + HIGH_W;
  localparam int unsigned LETTERS       = 15;
  localparam int unsigned TOTAL_W       = 32;
  localparam int unsigned ENTRY_W       = 1 + WORD_W + COUNT_BITS;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_MATCH = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_OUT
  } state_e;

  // One table entry as it sits in the RAM.
  typedef struct packed {
    logic                  valid;
    logic [HIGH_W-1:0]     high;
    logic [LOW_W-1:0]      low;
    logic [COUNT_BITS-1:0] copies;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_en;
    logic ld_item;
    logic rd_en;
    logic upd_en;
    logic out_set;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic addr_last;
    logic out_free;
  } sts_t;

  // Clear every letter from the first zero letter onward.
  function automatic logic [WORD_W-1:0] canon_word(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] r;
    logic              alive;
    r     = '0;
    alive = 1'b1;
    for (int k = 0; k < LETTERS; k++) begin
      if (w[5*k +: 5] == 5'd0) begin
        alive = 1'b0;
      end
      if (alive) begin
        r[5*k +: 5] = w[5*k +: 5];
      end
    end
    return r;
  endfunction

endpackage

@@ hdl/mic_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mic_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/mic_datapath.sv @@
// Datapath: item registers, table scan, entry update, match total and output register.
module mic_datapath import mic_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic                op_i,
  input  logic [WORD_W-1:0]   word_i,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic                matched_o,
  output logic [TOTAL_W-1:0]  total_o,
  output logic                full_o
);

  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [ADDR_W-1:0]  cmp_addr_q;
  logic               rd_vld_q;
  logic               op_q;
  logic [WORD_W-1:0]  word_q;
  logic               found_q, found_d;
  logic [ADDR_W-1:0]  hit_idx_q, hit_idx_d;
  logic [COUNT_BITS-1:0] hit_cnt_q, hit_cnt_d;
  logic               free_q, free_d;
  logic [ADDR_W-1:0]  free_idx_q, free_idx_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic               res_matched_q, res_matched_d;
  logic               res_full_q, res_full_d;
  logic               m_valid_q, m_valid_d;
  logic               out_matched_q;
  logic [TOTAL_W-1:0] out_total_q;
  logic               out_full_q;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  entry_t             wentry;
  entry_t             rentry;
  logic [ENTRY_W-1:0] rdata;

  // Scan address counter.
  always_comb begin
    addr_d = addr_q;
    if (cmd_i.ld_item) begin
      addr_d = '0;
    end else if (cmd_i.clr_en || cmd_i.rd_en) begin
      addr_d = (addr_q == ADDR_W'(TABLE_ENTRIES - 1)) ? '0 : addr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      addr_q   <= addr_d;
      rd_vld_q <= cmd_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_addr_q <= addr_q;
    if (cmd_i.ld_item) begin
      op_q   <= op_i;
      word_q <= canon_word(word_i);
    end
  end

  mic_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wentry),
    .re_i    (cmd_i.rd_en),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  assign rentry = entry_t'(rdata);

  // Compare each returned entry; keep the hit and the lowest free entry.
  always_comb begin
    found_d    = found_q;
    hit_idx_d  = hit_idx_q;
    hit_cnt_d  = hit_cnt_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    if (cmd_i.ld_item) begin
      found_d = 1'b0;
      free_d  = 1'b0;
    end else if (rd_vld_q) begin
      if (rentry.valid && ({rentry.high, rentry.low} == word_q) && !found_q) begin
        found_d   = 1'b1;
        hit_idx_d = cmp_addr_q;
        hit_cnt_d = rentry.copies;
      end
      if (!rentry.valid && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = cmp_addr_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      free_q  <= 1'b0;
    end else begin
      found_q <= found_d;
      free_q  <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q  <= hit_idx_d;
    hit_cnt_q  <= hit_cnt_d;
    free_idx_q <= free_idx_d;
  end

  // Entry update, result and table write.
  always_comb begin
    we            = 1'b0;
    waddr         = addr_q;
    wentry        = '0;
    total_d       = total_q;
    res_matched_d = res_matched_q;
    res_full_d    = res_full_q;
    if (cmd_i.clr_en) begin
      we = 1'b1;
    end else if (cmd_i.upd_en) begin
      res_matched_d = 1'b0;
      res_full_d    = 1'b0;
      wentry.high   = word_q[WORD_W-1:LOW_W];
      wentry.low    = word_q[LOW_W-1:0];
      wentry.valid  = 1'b1;
      if (op_q == OP_ADD) begin
        if (found_q) begin
          waddr = hit_idx_q;
          if (hit_cnt_q == '1) begin
            res_full_d = 1'b1;
          end else begin
            we            = 1'b1;
            wentry.copies = hit_cnt_q + 1'b1;
          end
        end else if (free_q) begin
          we            = 1'b1;
          waddr         = free_idx_q;
          wentry.copies = COUNT_BITS'(1);
        end else begin
          res_full_d = 1'b1;
        end
      end else if (found_q) begin
        res_matched_d = 1'b1;
        we            = 1'b1;
        waddr         = hit_idx_q;
        if (total_q != '1) begin
          total_d = total_q + 1'b1;
        end
        if (hit_cnt_q <= COUNT_BITS'(1)) begin
          wentry.valid = 1'b0;
        end else begin
          wentry.copies = hit_cnt_q - 1'b1;
        end
      end
    end
  end

  // Output register.
  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_i.out_set) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      total_q   <= total_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_matched_q <= res_matched_d;
    res_full_q    <= res_full_d;
    if (cmd_i.out_set) begin
      out_matched_q <= res_matched_q;
      out_total_q   <= total_q;
      out_full_q    <= res_full_q;
    end
  end

  assign sts_o.addr_last = (addr_q == ADDR_W'(TABLE_ENTRIES - 1));
  assign sts_o.out_free  = !m_valid_q || m_ready_i;
  assign m_valid_o       = m_valid_q;
  assign matched_o       = out_matched_q;
  assign total_o         = out_total_q;
  assign full_o          = out_full_q;

endmodule

@@ hdl/mic_ctrl.sv @@
// Controller state machine: clearing pass, item intake, table scan, update and result hand-off.
module mic_ctrl import mic_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (sts_i.addr_last) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN:   if (sts_i.addr_last) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_OUT;
      ST_OUT:    if (sts_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_en = 1'b1;
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.ld_item = in_valid_i;
      end
      ST_SCAN:   cmd_o.rd_en  = 1'b1;
      ST_DRAIN:  ;
      ST_UPDATE: cmd_o.upd_en = 1'b1;
      ST_OUT:    cmd_o.out_set = sts_i.out_free;
      default:   ;
    endcase
  end

endmodule

@@ hdl/multiset_intersection_counter.sv @@
// Flow: an accepted item is compared against every table entry in a scan, then passes the drain,
// update and output states; a stalled receiver holds it in the output state. The table RAM is scanned
// linearly, one entry read per cycle through its single read port, so items are taken one at a time.
// Reset: asynchronous, active low; clears the match total, then a clearing pass
// marks every table entry free before the first input is accepted.
// Top level of the multiset intersection counter.
module multiset_intersection_counter import mic_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: word_low [59:0], word_high [74:60], zero pad [79:75]
  input  logic [79:0] s_axis_tdata_i,
  // tuser: op [0]
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: matched [0], match_total [32:1], full_res [33], zero pad [39:34]
  output logic [39:0] m_axis_tdata_o
);

  cmd_t               cmd;
  sts_t               sts;
  logic               matched;
  logic [TOTAL_W-1:0] total;
  logic               full;

  mic_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mic_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .op_i      (s_axis_tuser_i),
    .word_i    (s_axis_tdata_i[WORD_W-1:0]),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .matched_o (matched),
    .total_o   (total),
    .full_o    (full)
  );

  assign m_axis_tdata_o = {6'd0, full, total, matched};

endmodule

@@ hdl/mic_checker.sv @@
// Port-level checker for the intersection counter, bound to the top level.
module mic_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // One item at a time: no input transfer right after one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted during scan");

  // A result is never both matched and full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && m_axis_tdata_o[33]))
    else $error("matched and full together");

  // A matched result carries a nonzero total.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |-> m_axis_tdata_o[32:1] != 32'd0)
    else $error("matched with zero total");

endmodule

bind multiset_intersection_counter mic_checker u_mic_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

@@ bench/tb_multiset_intersection_counter.sv @@
// Self-checking testbench for the multiset intersection counter.
module tb_multiset_intersection_counter;
  import mic_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [WORD_W-1:0] word_t;

  // One result as it comes out of the block.
  typedef struct packed {
    logic               matched;
    logic [TOTAL_W-1:0] total;
    logic               full;
  } tally_t;

  // One row of the directed stimulus table.
  typedef struct {
    logic   op;
    word_t  word;
    bit     known;
    tally_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [79:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;

  multiset_intersection_counter dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i),
    .s_axis_tuser_i(s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the word table and the running total.
  bit                    shadow_valid [TABLE_ENTRIES];
  word_t                 shadow_word  [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0] shadow_copies[TABLE_ENTRIES];
  logic [TOTAL_W-1:0]    shadow_total = '0;

  tally_t    tally_q[$];
  stim_row_t rows[$];
  word_t     added_words[$];
  int        errors = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  // Trim a word at its first zero letter.
  function automatic word_t trim_word(word_t w);
    word_t r;
    bit    alive;
    r = '0;
    alive = 1'b1;
    for (int k = 0; k < LETTERS; k++) begin
      if (w[5*k +: 5] == 5'd0) alive = 1'b0;
      if (alive) r[5*k +: 5] = w[5*k +: 5];
    end
    return r;
  endfunction

  // Apply one item to the shadow table and return the result it should give.
  function automatic tally_t tally_step(logic op, word_t raw);
    tally_t t;
    word_t  w;
    int     hit;
    int     free_slot;
    t = '0;
    w = trim_word(raw);
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (shadow_valid[i] && shadow_word[i] == w && hit < 0) hit = i;
      if (!shadow_valid[i] && free_slot < 0) free_slot = i;
    end
    if (op == OP_ADD) begin
      if (hit >= 0) begin
        if (&shadow_copies[hit]) t.full = 1'b1;
        else shadow_copies[hit] = shadow_copies[hit] + 1'b1;
      end else if (free_slot < 0) begin
        t.full = 1'b1;
      end else begin
        shadow_valid[free_slot]  = 1'b1;
        shadow_word[free_slot]   = w;
        shadow_copies[free_slot] = COUNT_BITS'(1);
      end
    end else if (hit >= 0) begin
      t.matched = 1'b1;
      if (!(&shadow_total)) shadow_total = shadow_total + 1'b1;
      if (shadow_copies[hit] <= 1) shadow_valid[hit] = 1'b0;
      else shadow_copies[hit] = shadow_copies[hit] - 1'b1;
    end
    t.total = shadow_total;
    return t;
  endfunction

  // Pack a lowercase string into letter codes.
  function automatic word_t spell(string s);
    word_t w;
    w = '0;
    for (int k = 0; k < s.len() && k < LETTERS; k++) w[5*k +: 5] = 5'(s[k] - 8'd96);
    return w;
  endfunction

  // Random word with a length between min_len and max_len; letters after the end mark are junk.
  function automatic word_t rand_word(int alpha, int min_len, int max_len);
    word_t w;
    int    len;
    w = '0;
    len = $urandom_range(max_len, min_len);
    for (int k = 0; k < LETTERS; k++) begin
      if (k < len) w[5*k +: 5] = 5'($urandom_range(alpha, 1));
      else if (k > len) w[5*k +: 5] = 5'($urandom_range(31, 0));
    end
    return w;
  endfunction

  function automatic tally_t mk_tally(logic m, int unsigned tot, logic f);
    tally_t t;
    t.matched = m;
    t.total = tot;
    t.full = f;
    return t;
  endfunction

  // Drive one item and wait for its transfer; called right after a rising edge.
  task automatic send_item(logic op, word_t w, bit known, tally_t want);
    tally_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {5'b0, w};
    do @(negedge clk_i); while (!s_axis_tready_o);
    @(posedge clk_i);
    predicted = tally_step(op, w);
    tally_q.push_back(known ? want : predicted);
  endtask

  // Random receiver stalls.
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check each result transfer against the oldest expectation.
  always @(negedge clk_i) begin
    tally_t got;
    tally_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tdata_o[0], m_axis_tdata_o[32:1], m_axis_tdata_o[33]};
      if (tally_q.size() == 0) begin
        $display("%0t: unexpected result matched=%0b total=%0d full=%0b",
                 $time, got.matched, got.total, got.full);
        errors++;
      end else begin
        want = tally_q.pop_front();
        if (got.matched !== want.matched) begin
          $display("%0t: matched expected %0b actual %0b", $time, want.matched, got.matched);
          errors++;
        end
        if (got.total !== want.total) begin
          $display("%0t: match_total expected %0d actual %0d", $time, want.total, got.total);
          errors++;
        end
        if (got.full !== want.full) begin
          $display("%0t: full_res expected %0b actual %0b", $time, want.full, got.full);
          errors++;
        end
      end
    end
  end

  // Stimulus.
  initial begin
    word_t     w;
    int        pick;
    // Directed rows: empty table, empty word, junk after end, high codes, extremes.
    rows.push_back('{OP_MATCH, spell("cat"), 1, mk_tally(0, 0, 0)});
    rows.push_back('{OP_ADD, '0, 1, mk_tally(0, 0, 0)});
    rows.push_back('{OP_MATCH, {WORD_W{1'b1}} << 5, 1, mk_tally(1, 1, 0)});
    rows.push_back('{OP_MATCH, '0, 1, mk_tally(0, 1, 0)});
    rows.push_back('{OP_ADD, spell("cat") | (75'h7FFF << 20), 0, '0});
    rows.push_back('{OP_ADD, spell("cat"), 0, '0});
    rows.push_back('{OP_MATCH, spell("cat"), 0, '0});
    rows.push_back('{OP_MATCH, spell("cat") | (75'h1F << 40), 0, '0});
    rows.push_back('{OP_MATCH, spell("cat"), 0, '0});
    rows.push_back('{OP_ADD, {WORD_W{1'b1}}, 0, '0});
    rows.push_back('{OP_ADD, {15'h0, {60{1'b1}}}, 0, '0});
    rows.push_back('{OP_MATCH, {WORD_W{1'b1}}, 0, '0});
    rows.push_back('{OP_MATCH, {WORD_W{1'b1}}, 0, '0});
    rows.push_back('{OP_ADD, spell("zzzzzzzzzzzzzzz"), 0, '0});
    rows.push_back('{OP_ADD, {15'h7BDE, 60'h0}, 0, '0});
    rows.push_back('{OP_MATCH, spell("zzzzzzzzzzzzzzz"), 0, '0});
    rows.push_back('{OP_MATCH, {15'h0, {60{1'b1}}}, 0, '0});
    rows.push_back('{OP_ADD, 75'h3FF & ~75'h1F | 75'd27, 0, '0});
    rows.push_back('{OP_MATCH, 75'd27, 0, '0});
    rows.push_back('{OP_MATCH, 75'd27, 0, '0});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_item(rows[i].op, rows[i].word, rows[i].known, rows[i].want);

    // Fill the table with 1040 adds, mostly of long words.
    for (int n = 0; n < 1040; n++) begin
      pick = n / 100 % 4;
      send_idle_pct  = (pick == 1) ? 57 : (pick == 3) ? 21 : 0;
      recv_stall_pct = (pick == 2) ? 57 : (pick == 3) ? 21 : 0;
      if ($urandom_range(9) == 0) begin
        send_item(OP_ADD, rand_word(3, 0, 3), 0, '0);
      end else begin
        w = rand_word(31, 8, 15);
        added_words.push_back(w);
        send_item(OP_ADD, w, 0, '0);
      end
    end

    // Mixed adds and matches that free entries and reuse them.
    for (int n = 0; n < 290; n++) begin
      pick = n / 60 % 4;
      send_idle_pct  = (pick == 1) ? 57 : (pick == 3) ? 21 : 0;
      recv_stall_pct = (pick == 2) ? 57 : (pick == 3) ? 21 : 0;
      pick = $urandom_range(9);
      if (pick < 3) send_item(OP_MATCH, added_words[$urandom_range(added_words.size() - 1)], 0, '0);
      else if (pick < 6) send_item(OP_ADD, rand_word(3, 0, 3), 0, '0);
      else if (pick < 9) send_item(OP_MATCH, rand_word(3, 0, 3), 0, '0);
      else send_item(1'($urandom_range(1)), rand_word(31, 0, 15), 0, '0);
    end
    s_axis_tvalid_i <= 1'b0;

    // Drain the outstanding results.
    recv_stall_pct = 0;
    while (tally_q.size() != 0) @(posedge clk_i);
    repeat (1100) @(posedge clk_i);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Watchdog.
  initial begin
    #200ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ files.f @@
hdl/mic_pkg.sv
hdl/mic_ram.sv
hdl/mic_datapath.sv
hdl/mic_ctrl.sv
hdl/multiset_intersection_counter.sv
hdl/mic_checker.sv
bench/tb_multiset_intersection_counter.sv
